### sv/far_pkg.sv
// package for the fraction add and reduce block
// shared constants and the controller state type; no dependencies
`default_nettype none
package far_pkg;
  localparam int WIDTH_DEF = 32;
  localparam int SUM_W = 64;
  localparam int DEN_W = 62;
  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_PREP, ST_GCD_CHK, ST_GCD_DIV, ST_GCD_SWAP,
    ST_QDIV, ST_FINISH, ST_OUT
  } state_t;
endpackage
`default_nettype wire

### sv/fraction_add_reduce_top.sv
// fraction add with gcd reduction, bit-serial datapath
// depends on far_pkg
// steps: shift-add multiply, a prep state, then euclid with a restoring bit-serial
// remainder unit (each step: check, divide, swap; up to about 90 steps), a final check,
// two bit-serial divisions by the gcd, a finish state and an output state
// one transaction at a time; most of the run time goes to the single shared
// 1-bit-per-cycle divide loop
// reset: rst returns the controller to idle; datapath registers are not reset
`default_nettype none
module fraction_add_reduce_top #(
  parameter int WIDTH = far_pkg::WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // a_num[W-1:0], a_den[W-2:0], b_num, b_den, zero fill to bytes
  input  wire logic [((4*WIDTH-2+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // sum_num[63:0], sum_den[125:64], zero fill to 128 bits
  output logic [127:0] m_tdata
);
  import far_pkg::*;

  localparam int DW = WIDTH - 1;
  localparam int BO = WIDTH + DW;

  state_t state, state_next;

  logic [63:0] acc;      // s accumulator, then magnitude
  logic [63:0] dacc;     // denominator product
  logic [63:0] mcand_a, mcand_b; // sign-extended an, bn shifted left
  logic [63:0] mcand_ad;
  logic [DW-1:0] mplier_bd, mplier_ad; // shifted right
  logic [6:0] cnt;
  logic neg;
  logic [63:0] gx, gy;   // euclid operands
  logic [63:0] rem, quo; // divider
  logic [63:0] dvd;      // dividend shift
  logic [63:0] dvs;
  logic qsel;            // 0: mag quotient, 1: den quotient
  logic [63:0] mag_q;
  logic [63:0] rem_sh;
  logic [64:0] diff;

  assign s_tready = (state == ST_IDLE);

  assign rem_sh = {rem[62:0], dvd[63]};
  assign diff = {1'b0, rem_sh} - {1'b0, dvs};
  wire rem_top = rem[63];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_MUL;
      ST_MUL: if (cnt == 7'(DW - 1)) state_next = ST_PREP;
      ST_PREP: state_next = ST_GCD_CHK;
      ST_GCD_CHK: begin
        if (gy == '0) state_next = ST_QDIV;
        else state_next = ST_GCD_DIV;
      end
      ST_GCD_DIV: if (cnt == 7'd63) state_next = ST_GCD_SWAP;
      ST_GCD_SWAP: state_next = ST_GCD_CHK;
      ST_QDIV: begin
        if (gx == '0) state_next = ST_FINISH;
        else if (cnt == 7'd63 && qsel) state_next = ST_FINISH;
      end
      ST_FINISH: state_next = ST_OUT;
      ST_OUT: if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    m_tvalid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        mcand_a <= 64'(signed'(s_tdata[WIDTH-1:0]));
        mcand_b <= 64'(signed'(s_tdata[BO+WIDTH-1:BO]));
        mcand_ad <= 64'(s_tdata[WIDTH+DW-1:WIDTH]);
        mplier_bd <= s_tdata[BO+WIDTH+DW-1:BO+WIDTH];
        mplier_ad <= s_tdata[WIDTH+DW-1:WIDTH];
        acc <= '0;
        dacc <= '0;
        cnt <= '0;
      end
      ST_MUL: begin
        // one bit of each multiplier per cycle
        acc <= acc + (mplier_bd[0] ? mcand_a : 64'd0) + (mplier_ad[0] ? mcand_b : 64'd0);
        dacc <= dacc + (mplier_bd[0] ? mcand_ad : 64'd0);
        mcand_a <= {mcand_a[62:0], 1'b0};
        mcand_b <= {mcand_b[62:0], 1'b0};
        mcand_ad <= {mcand_ad[62:0], 1'b0};
        mplier_bd <= mplier_bd >> 1;
        mplier_ad <= mplier_ad >> 1;
        cnt <= cnt + 7'd1;
      end
      ST_PREP: begin
        neg <= acc[63];
        acc <= acc[63] ? (64'd0 - acc) : acc;
        gx <= acc[63] ? (64'd0 - acc) : acc;
        gy <= dacc;
      end
      ST_GCD_CHK: begin
        // start gx mod gy, or the first quotient
        rem <= '0;
        cnt <= '0;
        quo <= '0;
        qsel <= 1'b0;
        if (gy == '0) begin
          dvd <= acc;
          dvs <= gx;
        end else begin
          dvd <= gx;
          dvs <= gy;
        end
      end
      ST_GCD_DIV, ST_QDIV: begin
        // restoring divide, one quotient bit per cycle
        dvd <= {dvd[62:0], 1'b0};
        if (rem_top || !diff[64]) begin
          rem <= diff[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (state == ST_QDIV && cnt == 7'd63 && !qsel) begin
          mag_q <= {quo[62:0], (rem_top || !diff[64])};
          qsel <= 1'b1;
          rem <= '0;
          quo <= '0;
          dvd <= dacc;
          cnt <= '0;
        end
      end
      ST_GCD_SWAP: begin
        gx <= gy;
        gy <= rem;
      end
      ST_FINISH: begin
        if (gx != '0) begin
          acc <= neg ? (64'd0 - mag_q) : mag_q;
          dacc <= quo;
        end else begin
          acc <= neg ? (64'd0 - acc) : acc;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {2'b00, dacc[61:0], acc};

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("out changed");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_tready) else $error("ready while busy");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_MUL) else $error("accept did not start multiply");
`endif
endmodule
`default_nettype wire

### dv/fraction_add_reduce_top_tb.sv
// testbench for the fraction add and reduce block: random and directed fraction pairs,
// sums predicted in a scoreboard class and checked field by field
// depends on far_pkg and fraction_add_reduce_top
`timescale 1ns / 100ps
`default_nettype none

class fraction_sum_board;
  logic [63:0]  sum_num_q[$];
  logic [61:0]  sum_den_q[$];
  int unsigned  mismatches;
  int unsigned  sums_checked;

  function void note_operands(logic [31:0] an, logic [30:0] ad, logic [31:0] bn,
                              logic [30:0] bd);
    logic [63:0] s, d, mag, x, y, t;
    logic        neg;
    s = {{32{an[31]}}, an} * {33'd0, bd} + {{32{bn[31]}}, bn} * {33'd0, ad};
    d = {33'd0, ad} * {33'd0, bd};
    neg = s[63];
    mag = neg ? -s : s;
    x = mag;
    y = d;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x != 0) begin
      mag = mag / x;
      d = d / x;
    end
    sum_num_q.push_back(neg ? -mag : mag);
    sum_den_q.push_back(d[61:0]);
  endfunction

  function void check_sum(logic [127:0] data);
    logic [63:0] en;
    logic [61:0] ed;
    sums_checked++;
    if (sum_num_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected sum transaction %h", data);
      return;
    end
    en = sum_num_q.pop_front();
    ed = sum_den_q.pop_front();
    if (data[63:0] !== en || data[125:64] !== ed || data[127:126] !== 2'b00) begin
      mismatches++;
      if (mismatches <= 10)
        $display("sum mismatch: expected %0d/%0d got %0d/%0d", $signed(en), ed,
                 $signed(data[63:0]), data[125:64]);
    end
  endfunction
endclass

module fraction_add_reduce_top_tb;
  import far_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;

  fraction_sum_board board = new();
  longint cycles = 0;
  bit quiet_phase = 1'b0;     // no idling near the end
  bit hold_sink = 1'b0;       // long receiver hold-off
  int unsigned items_sent = 0;

  always #5 clk = ~clk;

  fraction_add_reduce_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // cycle counter with a generous timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // check every accepted result transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_sum(m_tdata);
  end

  // receiver: random bursts of stall, held low throughout the hold-off, none in the quiet phase
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        @(posedge clk);
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // long hold-off counted in its own process while the sender keeps offering
  initial begin
    @(posedge clk iff items_sent == 40);
    hold_sink = 1'b1;
    repeat (3000) @(posedge clk);
    hold_sink = 1'b0;
  end

  // offer one fraction pair and wait for the input transaction
  task automatic send_pair(logic [31:0] an, logic [30:0] ad, logic [31:0] bn, logic [30:0] bd);
    int n;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'd0, bd, bn, ad, an};
    @(posedge clk iff s_tready);
    board.note_operands(an, ad, bn, bd);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_num();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20) - 10;
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      3: return $urandom_range(0, 2000) - 1000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(0, 12));
      1: return 31'h7fff_ffff - 31'($urandom_range(0, 3));
      2: return 31'd1 << $urandom_range(0, 30);
      3: return 31'($urandom_range(1, 1000));
      default: return 31'($urandom());
    endcase
  endfunction

  initial begin
    logic [31:0] n1;
    logic [30:0] d1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero sums, zero denominators, most negative numerator
    send_pair(32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    send_pair(32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    send_pair(32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);
    send_pair(32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
    send_pair(32'h8000_0000, 31'd1, 32'h7fff_ffff, 31'h7fff_ffff);
    send_pair(32'd1, 31'd2, 32'd1, 31'd2);
    send_pair(32'd1, 31'd3, -32'd1, 31'd3);
    send_pair(32'd0, 31'd1, 32'd0, 31'd1);
    send_pair(32'd5, 31'd0, 32'd3, 31'd7);
    send_pair(-32'd5, 31'd0, 32'd3, 31'd7);
    send_pair(32'd0, 31'd0, 32'd0, 31'd0);
    send_pair(32'd4, 31'd0, -32'd4, 31'd0);
    send_pair(32'hffff_ffff, 31'h5555_5555, 32'h5555_5555, 31'h2aaa_aaaa);
    send_pair(32'haaaa_aaaa, 31'h2aaa_aaaa, 32'h5555_5555, 31'h5555_5555);
    send_pair(32'd6, 31'd4, 32'd10, 31'd4);
    send_pair(32'h4000_0000, 31'h4000_0000, 32'hc000_0000, 31'h4000_0000);

    // random pairs, some built to cancel or share factors
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 150) quiet_phase = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        n1 = pick_num();
        d1 = pick_den();
        send_pair(n1, d1, -n1, d1);
      end else begin
        send_pair(pick_num(), pick_den(), pick_num(), pick_den());
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk iff board.sum_num_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d fraction pairs incl. extremes, zero sums and zero denominators",
             items_sent);
    $display("checked %0d sums, %0d mismatches", board.sums_checked, board.mismatches);
    if (board.mismatches == 0 && board.sum_num_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

`default_nettype wire
